// File: src/cwba_pkg.sv
// ----------------------------------------------------------------------------
// cwba_pkg: white balance averager shared definitions
// Widths, constants, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cwba_pkg;

	localparam int SAMPLES_PER_WINDOW = 6;
	localparam int SAMPLE_BITS        = 16;

	localparam int FIELD_W = 16;
	localparam int NUM_CH  = 3;
	localparam int CH_W    = 2;
	localparam int PIX_W   = 8;
	localparam int GAIN_W  = 24;
	localparam int FRAC_W  = 16;
	localparam int CNT_W   = $clog2(SAMPLES_PER_WINDOW + 1);
	localparam int ACC_W   = SAMPLE_BITS + $clog2(SAMPLES_PER_WINDOW);
	localparam int DIV_W   = (ACC_W > GAIN_W) ? ACC_W : GAIN_W;
	localparam int DCNT_W  = $clog2(DIV_W + 1);
	localparam int PROD_W  = SAMPLE_BITS + GAIN_W;

	// The window average is a multiplication by a rounded-up reciprocal of
	// the window length; the shift is wide enough for the quotient to be exact
	// over the whole range of the sums.
	localparam int RECIP_SHIFT = ACC_W + $clog2(SAMPLES_PER_WINDOW);
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int AVGP_W      = ACC_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((longint'(1) << RECIP_SHIFT)
		+ longint'(SAMPLES_PER_WINDOW - 1)) / longint'(SAMPLES_PER_WINDOW));

	localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};
	localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << FRAC_W;
	localparam logic [PIX_W-1:0]  WHITE_LEVEL = {PIX_W{1'b1}};
	localparam logic [DIV_W-1:0]  WHITE_SCALED = DIV_W'(WHITE_LEVEL) << FRAC_W;
	localparam logic [CH_W-1:0]   LAST_CH = CH_W'(NUM_CH - 1);

	localparam logic MODE_MEASURE   = 1'b0;
	localparam logic MODE_CALIBRATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_GAIN_START,
		ST_GAIN_WAIT,
		ST_MUL,
		ST_SAT,
		ST_NEXT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic            take;
		logic            avg_load;
		logic            gain_start;
		logic            gain_load;
		logic            gain_sat;
		logic            mul;
		logic            sat_load;
		logic            out_load;
		logic [CH_W-1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic accept;
		logic complete;
		logic div_done;
		logic calibrate;
		logic avg_zero;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: src/cwba_if.sv
// ----------------------------------------------------------------------------
// cwba_in_if, cwba_out_if: sample and result channels
// Valid and ready handshake channels carrying one sample triple or one
// balanced colour result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwba_in_if;
	import cwba_pkg::*;
	logic               valid;
	logic               ready;
	logic               command;
	logic [FIELD_W-1:0] red_sample;
	logic [FIELD_W-1:0] green_sample;
	logic [FIELD_W-1:0] blue_sample;

	modport source (
		output valid, command, red_sample, green_sample, blue_sample,
		input  ready
	);
	modport sink (
		input  valid, command, red_sample, green_sample, blue_sample,
		output ready
	);
endinterface

interface cwba_out_if;
	import cwba_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic             calibration_done;

	modport source (
		output valid, red_out, green_out, blue_out, calibration_done,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out, calibration_done,
		output ready
	);
endinterface

`default_nettype wire

// File: src/cwba_divider.sv
// ----------------------------------------------------------------------------
// cwba_divider: restoring serial divider
// Produces one quotient bit per cycle; used for the calibration gains.
// ----------------------------------------------------------------------------
`default_nettype none

module cwba_divider
	import cwba_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [DIV_W-1:0]       dividend,
	input  wire logic [SAMPLE_BITS-1:0] divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            quotient
);

	logic [DIV_W-1:0]       quo_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] dsr_q;
	logic [DCNT_W-1:0]      cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [SAMPLE_BITS:0]   rem_shift;
	logic                   fits;

	assign rem_shift = {rem_q, quo_q[DIV_W-1]};
	assign fits      = rem_shift >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			if (fits) begin
				rem_q <= SAMPLE_BITS'(rem_shift - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_shift[SAMPLE_BITS-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// File: src/cwba_datapath.sv
// ----------------------------------------------------------------------------
// cwba_datapath: accumulators, gains and result register
// Holds the window sums, the per-channel gains, the multiplier stage and
// the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module cwba_datapath
	import cwba_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic               in_valid,
	input  wire logic               command,
	input  wire logic [FIELD_W-1:0] red_sample,
	input  wire logic [FIELD_W-1:0] green_sample,
	input  wire logic [FIELD_W-1:0] blue_sample,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [PIX_W-1:0]        red_out,
	output logic [PIX_W-1:0]        green_out,
	output logic [PIX_W-1:0]        blue_out,
	output logic                    calibration_done
);

	logic [CNT_W-1:0]       count_q;
	logic                   mode_q;
	logic [ACC_W-1:0]       acc_q [NUM_CH];
	logic [GAIN_W-1:0]      gain_q [NUM_CH];
	logic [SAMPLE_BITS-1:0] avg_q;
	logic [PROD_W-1:0]      prod_s1;
	logic [PIX_W-1:0]       res_q [NUM_CH];
	logic                   out_valid_q;
	logic [PIX_W-1:0]       red_q;
	logic [PIX_W-1:0]       green_q;
	logic [PIX_W-1:0]       blue_q;
	logic                   done_q;

	logic [SAMPLE_BITS-1:0] sample [NUM_CH];
	logic                   fresh;
	logic [CNT_W-1:0]       next_count;
	logic                   accept;
	logic [AVGP_W-1:0]      avg_prod;
	logic                   div_start;
	logic [DIV_W-1:0]       div_dividend;
	logic [SAMPLE_BITS-1:0] div_divisor;
	logic                   div_done;
	logic [DIV_W-1:0]       div_quotient;
	logic [PROD_W-FRAC_W-1:0] prod_int;
	logic [PIX_W-1:0]       sat_value;

	assign sample[0] = red_sample[SAMPLE_BITS-1:0];
	assign sample[1] = green_sample[SAMPLE_BITS-1:0];
	assign sample[2] = blue_sample[SAMPLE_BITS-1:0];

	assign accept     = in_valid && cmd.take;
	assign fresh      = (command != mode_q) || (count_q == '0);
	assign next_count = fresh ? CNT_W'(1) : count_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mode_q  <= MODE_MEASURE;
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c] <= '0;
			end
		end else if (accept) begin
			mode_q  <= command;
			count_q <= (next_count == CNT_W'(SAMPLES_PER_WINDOW)) ? '0 : next_count;
			for (int c = 0; c < NUM_CH; c++) begin
				if (fresh) begin
					acc_q[c] <= ACC_W'(sample[c]);
				end else begin
					acc_q[c] <= acc_q[c] + ACC_W'(sample[c]);
				end
			end
		end
	end

	assign avg_prod = AVGP_W'(acc_q[cmd.ch]) * AVGP_W'(RECIP);

	assign div_start    = cmd.gain_start;
	assign div_dividend = WHITE_SCALED;
	assign div_divisor  = avg_q;

	cwba_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				gain_q[c] <= GAIN_UNITY;
			end
		end else if (cmd.gain_sat) begin
			gain_q[cmd.ch] <= GAIN_MAX;
		end else if (cmd.gain_load) begin
			gain_q[cmd.ch] <= div_quotient[GAIN_W-1:0];
		end
	end

	assign prod_int  = prod_s1[PROD_W-1:FRAC_W];
	assign sat_value = (prod_int > (PROD_W-FRAC_W)'(WHITE_LEVEL)) ? WHITE_LEVEL
		: prod_int[PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.avg_load) begin
			avg_q <= avg_prod[RECIP_SHIFT +: SAMPLE_BITS];
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(avg_q) * PROD_W'(gain_q[cmd.ch]);
		end
		if (cmd.sat_load) begin
			res_q[cmd.ch] <= sat_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (mode_q == MODE_CALIBRATE) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				done_q  <= 1'b1;
			end else begin
				red_q   <= res_q[0];
				green_q <= res_q[1];
				blue_q  <= res_q[2];
				done_q  <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign red_out          = red_q;
	assign green_out        = green_q;
	assign blue_out         = blue_q;
	assign calibration_done = done_q;

	assign status.accept    = accept;
	assign status.complete  = next_count == CNT_W'(SAMPLES_PER_WINDOW);
	assign status.div_done  = div_done;
	assign status.calibrate = mode_q == MODE_CALIBRATE;
	assign status.avg_zero  = avg_q == '0;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

`default_nettype wire

// File: src/cwba_ctrl.sv
// ----------------------------------------------------------------------------
// cwba_ctrl: window sequencer
// Takes samples, and at the end of a window walks the three channels
// through averaging, gain update or balancing, then issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cwba_ctrl
	import cwba_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t          state_q;
	state_t          state_d;
	logic [CH_W-1:0] ch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				ch_q <= '0;
			end else if (state_q == ST_NEXT && ch_q != LAST_CH) begin
				ch_q <= ch_q + CH_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.accept && status.complete) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: state_d = status.calibrate ? ST_GAIN_START : ST_MUL;
			ST_GAIN_START: state_d = status.avg_zero ? ST_NEXT : ST_GAIN_WAIT;
			ST_GAIN_WAIT: begin
				if (status.div_done) begin
					state_d = ST_NEXT;
				end
			end
			ST_MUL: state_d = ST_SAT;
			ST_SAT: state_d = ST_NEXT;
			ST_NEXT: state_d = (ch_q == LAST_CH) ? ST_WRITE : ST_AVG;
			ST_WRITE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		cmd.ch = ch_q;
		unique case (state_q)
			ST_IDLE:       cmd.take = 1'b1;
			ST_AVG:        cmd.avg_load = 1'b1;
			ST_GAIN_START: begin
				cmd.gain_sat   = status.avg_zero;
				cmd.gain_start = !status.avg_zero;
			end
			ST_GAIN_WAIT:  cmd.gain_load = status.div_done;
			ST_MUL:        cmd.mul = 1'b1;
			ST_SAT:        cmd.sat_load = 1'b1;
			ST_NEXT:       ;
			ST_WRITE:      cmd.out_load = status.out_free;
			default:       ;
		endcase
	end

endmodule

`default_nettype wire

// File: src/color_white_balance_averager.sv
// ----------------------------------------------------------------------------
// color_white_balance_averager: windowed white balance
// Averages red, green and blue samples over a window, then either sets the
// channel gains and flags calibration_done or issues a balanced RGB888 item.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Carries
//   samples   in         valid/ready   command, red/green/blue samples
//   results   out        valid/ready   red/green/blue out, calibration_done
//
// A sample that does not end a window is taken without a stall. One that
// ends a window stalls the input while each channel passes through the
// average, multiply, saturate and next states in a measure window, or
// average, gain (serial divider, skipped for a zero average) and next in
// a calibration one, then a write issues the item. The result waits in an
// output register; a further window end waits for it to clear before
// issuing. Reset restores unity gains and an empty measure window at once.
// ----------------------------------------------------------------------------
`default_nettype none

module color_white_balance_averager
	import cwba_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	cwba_in_if.sink   samples,
	cwba_out_if.source results
);

	cmd_t    cmd;
	status_t status;

	assign samples.ready = cmd.take;

	cwba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	cwba_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_valid         (samples.valid),
		.command          (samples.command),
		.red_sample       (samples.red_sample),
		.green_sample     (samples.green_sample),
		.blue_sample      (samples.blue_sample),
		.out_valid        (results.valid),
		.out_ready        (results.ready),
		.red_out          (results.red_out),
		.green_out        (results.green_out),
		.blue_out         (results.blue_out),
		.calibration_done (results.calibration_done)
	);

endmodule

`default_nettype wire

// File: test/color_white_balance_averager_tb.sv
// ----------------------------------------------------------------------------
// color_white_balance_averager_tb: self-checking bench for the averager
// Sends sample items in bursts while the result side stalls on its own
// pattern. Each accepted sample is run through a local model of the window
// and gain logic, and every result item is compared field by field against
// the oldest predicted one.
// ----------------------------------------------------------------------------

module color_white_balance_averager_tb;
	import cwba_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             done;
	} pixel_t;

	logic clk;
	logic arst_n;

	cwba_in_if  samples_if ();
	cwba_out_if results_if ();

	color_white_balance_averager u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if)
	);

	pixel_t expected_pixels[$];
	int     errors;
	int     samples_sent;
	int     burst_left;
	int     stall_left;
	int     stall_kind;

	logic              window_mode;
	int unsigned       window_fill;
	logic [ACC_W-1:0]  channel_sum[NUM_CH];
	logic [GAIN_W-1:0] channel_gain[NUM_CH];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("color_white_balance_averager_tb NOT OK");
		$finish;
	end

	// Window and gain model, updated on every accepted sample item.
	task automatic accumulate_sample(input logic cmd,
			input logic [NUM_CH-1:0][FIELD_W-1:0] rgb);
		logic [ACC_W-1:0]  average;
		longint unsigned   scaled;
		pixel_t            pix;
		if (cmd != window_mode) begin
			window_mode = cmd;
			window_fill = 0;
			for (int c = 0; c < NUM_CH; c++) channel_sum[c] = '0;
		end
		for (int c = 0; c < NUM_CH; c++)
			channel_sum[c] = channel_sum[c] + ACC_W'(rgb[c][SAMPLE_BITS-1:0]);
		window_fill++;
		if (window_fill < SAMPLES_PER_WINDOW)
			return;
		pix = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			average = ACC_W'(channel_sum[c] / SAMPLES_PER_WINDOW);
			if (cmd == MODE_CALIBRATE) begin
				if (average == 0)
					channel_gain[c] = GAIN_MAX;
				else
					channel_gain[c] = GAIN_W'((longint'(WHITE_LEVEL) << FRAC_W) / average);
			end else begin
				scaled = (longint'(average) * longint'(channel_gain[c])) >> FRAC_W;
				if (scaled > WHITE_LEVEL)
					scaled = WHITE_LEVEL;
				case (c)
					0: pix.red   = PIX_W'(scaled);
					1: pix.green = PIX_W'(scaled);
					default: pix.blue = PIX_W'(scaled);
				endcase
			end
			channel_sum[c] = '0;
		end
		pix.done = (cmd == MODE_CALIBRATE);
		window_fill = 0;
		expected_pixels.push_back(pix);
	endtask

	// Entered and left at a falling edge; valid stays high across a burst.
	task automatic send_sample(input logic cmd, input logic [FIELD_W-1:0] r,
			input logic [FIELD_W-1:0] g, input logic [FIELD_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				samples_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		samples_if.valid        = 1'b1;
		samples_if.command      = cmd;
		samples_if.red_sample   = r;
		samples_if.green_sample = g;
		samples_if.blue_sample  = b;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		accumulate_sample(cmd, {b, g, r});
		samples_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] level_sample(input int level);
		case (level)
			0: return FIELD_W'($urandom);
			1: return FIELD_W'($urandom_range(0, 15));
			2: return FIELD_W'($urandom_range(65520, 65535));
			3: return FIELD_W'($urandom_range(100, 2000));
			default: return FIELD_W'($urandom_range(0, 300));
		endcase
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result item with no expectation waiting");
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("red_out", want.red, results_if.red_out);
				check_field("green_out", want.green, results_if.green_out);
				check_field("blue_out", want.blue, results_if.blue_out);
				check_field("calibration_done", want.done, results_if.calibration_done);
			end
		end
	end

	// Receiver stall pattern: free running, random, alternating or held off.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_kind = $urandom_range(0, 3);
			stall_left = (stall_kind == 3) ? $urandom_range(5, 150) : $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_kind)
			0: results_if.ready = 1'b1;
			1: results_if.ready = 1'($urandom_range(0, 1));
			2: results_if.ready = stall_left[0];
			default: results_if.ready = 1'b0;
		endcase
	end

	task automatic test_window_restart;
		repeat (3) send_sample(MODE_MEASURE, level_sample(0), level_sample(0), level_sample(0));
	endtask

	task automatic test_calibration_extremes;
		for (int i = 0; i < SAMPLES_PER_WINDOW; i++)
			send_sample(MODE_CALIBRATE, '0, '1, (i == 5) ? FIELD_W'(11) : FIELD_W'(6));
	endtask

	task automatic test_measure_extremes;
		for (int i = 0; i < SAMPLES_PER_WINDOW; i++)
			send_sample(MODE_MEASURE, (i == 5) ? FIELD_W'(6) : FIELD_W'(1), '1,
				(i == 5) ? FIELD_W'(9) : FIELD_W'(5));
	endtask

	task automatic test_mode_switch;
		repeat (2) send_sample(MODE_CALIBRATE, level_sample(0), level_sample(0),
			level_sample(0));
		repeat (SAMPLES_PER_WINDOW) send_sample(MODE_MEASURE, '0, '0, '0);
	endtask

	task automatic test_random_windows;
		logic cmd;
		int   len;
		int   level[NUM_CH];
		while (samples_sent < 1050) begin
			cmd = ($urandom_range(0, 3) == 0) ? MODE_CALIBRATE : MODE_MEASURE;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SAMPLES_PER_WINDOW - 1)
				: SAMPLES_PER_WINDOW;
			for (int c = 0; c < NUM_CH; c++) level[c] = $urandom_range(0, 4);
			repeat (len) send_sample(cmd, level_sample(level[0]), level_sample(level[1]),
				level_sample(level[2]));
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		samples_if.valid        = 1'b0;
		samples_if.command      = MODE_MEASURE;
		samples_if.red_sample   = '0;
		samples_if.green_sample = '0;
		samples_if.blue_sample  = '0;
		results_if.ready        = 1'b0;
		errors       = 0;
		samples_sent = 0;
		burst_left   = 0;
		stall_left   = 0;
		stall_kind   = 0;
		window_mode  = MODE_MEASURE;
		window_fill  = 0;
		for (int c = 0; c < NUM_CH; c++) begin
			channel_sum[c]  = '0;
			channel_gain[c] = GAIN_UNITY;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_window_restart();
		test_calibration_extremes();
		test_measure_extremes();
		test_mode_switch();
		test_random_windows();

		samples_if.valid = 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("color_white_balance_averager_tb OK");
		else
			$display("color_white_balance_averager_tb NOT OK");
		$finish;
	end

endmodule

// File: files.f
src/cwba_pkg.sv
src/cwba_if.sv
src/cwba_divider.sv
src/cwba_datapath.sv
src/cwba_ctrl.sv
src/color_white_balance_averager.sv
test/color_white_balance_averager_tb.sv
